// File: sv/dce_pkg.sv
// Package for the delimited column editor: widths, command and register codes,
// configuration and result-push structs. No dependencies.
package dce_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_DELIMS  = 8;
	localparam int DSET_W      = BYTE_W * MAX_DELIMS;
	localparam int DCNT_W      = 4;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = $clog2(RES_DEPTH);
	localparam int RES_CNT_W   = RES_PTR_W + 1;

	localparam logic [COL_W-1:0]  MAX_COLUMNS  = 10'd1023;
	localparam logic [ROW_W-1:0]  MAX_ROWS     = 16'd65535;
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_APPEND = 2'd3
	} column_command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIMITER_SET     = 3'd0,
		REG_DELIMITER_COUNT   = 3'd1,
		REG_COLUMN_COMMAND    = 3'd2,
		REG_FIRST_COLUMN      = 3'd3,
		REG_LAST_COLUMN       = 3'd4,
		REG_FIRST_DROPPED_ROW = 3'd5,
		REG_LAST_DROPPED_ROW  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DSET_W-1:0] delimiter_set;
		logic [DCNT_W-1:0] delimiter_count;
		column_command_t   column_command;
		logic [COL_W-1:0]  first_column;
		logic [COL_W-1:0]  last_column;
		logic [ROW_W-1:0]  first_dropped_row;
		logic [ROW_W-1:0]  last_dropped_row;
	} cfg_t;

	// Up to two result bytes from one item; cnt is how many are valid.
	typedef struct packed {
		logic [1:0]        cnt;
		logic [BYTE_W-1:0] res0;
		logic [BYTE_W-1:0] res1;
	} push_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
	} res_entry_t;

endpackage

// File: sv/dce_text_if.sv
// Input channel of the delimited column editor: one text byte per item.
// Depends on dce_pkg.
interface dce_text_if import dce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

// File: sv/dce_result_if.sv
// Output channel of the delimited column editor: one edited byte per item.
// Depends on dce_pkg.
interface dce_result_if import dce_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: sv/dce_cfg_if.sv
// Configuration write channel of the delimited column editor.
// Depends on dce_pkg.
interface dce_cfg_if import dce_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/dce_edit_core.sv
// Edit stage: input register, delimiter match, column/row counters and the
// result bytes for one item. Depends on dce_pkg and dce_text_if.
module dce_edit_core import dce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dce_text_if.sink   text_in,
	input  cfg_t       cfg,
	input  logic       room,
	output push_t      push
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	logic [COL_W-1:0]  column_index_q, column_index_d;
	logic [ROW_W-1:0]  row_index_q, row_index_d;
	logic              at_row_start_q, at_row_start_d;
	logic              kept_seen_q, kept_seen_d;

	logic [DCNT_W-1:0] n_eff;
	logic              is_delim;
	logic [BYTE_W-1:0] od;
	logic              drop;
	logic              kept_seen_eff;
	logic              pre;
	logic              col_step;
	logic [COL_W-1:0]  col_inc;
	logic [1:0]        m_cnt;
	logic [BYTE_W-1:0] m0, m1;
	logic [1:0]        n_res;
	logic [BYTE_W-1:0] r0, r1;

	function automatic logic col_kept(cfg_t c, logic [COL_W-1:0] col);
		logic in_range;
		in_range = (col >= c.first_column) && (col <= c.last_column);
		return (c.column_command != CMD_DELETE) || !in_range;
	endfunction

	assign advance       = valid_s1 && room;
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.valid && text_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			byte_s1 <= text_in.text_byte;
		end
	end

	always_comb begin
		n_eff = cfg.delimiter_count;
		if (n_eff == '0) n_eff = DCNT_W'(1);
		if (n_eff > DCNT_W'(MAX_DELIMS)) n_eff = DCNT_W'(MAX_DELIMS);
		is_delim = 1'b0;
		for (int k = 0; k < MAX_DELIMS; k++) begin
			if ((DCNT_W'(k) < n_eff) && (cfg.delimiter_set[BYTE_W*k +: BYTE_W] == byte_s1))
				is_delim = 1'b1;
		end
	end

	always_comb begin
		od   = cfg.delimiter_set[BYTE_W-1:0];
		drop = (cfg.first_dropped_row != '0) && (row_index_q >= cfg.first_dropped_row) &&
			(row_index_q <= cfg.last_dropped_row);
		kept_seen_eff = at_row_start_q ? col_kept(cfg, COL_W'(1)) : kept_seen_q;
		pre = at_row_start_q && (cfg.column_command == CMD_INSERT) &&
			(cfg.first_column == COL_W'(1));
		col_step = column_index_q < MAX_COLUMNS;
		col_inc  = col_step ? column_index_q + COL_W'(1) : column_index_q;

		m_cnt          = 2'd0;
		m0             = od;
		m1             = NEWLINE_BYTE;
		column_index_d = column_index_q;
		row_index_d    = row_index_q;
		at_row_start_d = 1'b0;
		kept_seen_d    = kept_seen_eff;

		if (byte_s1 == NEWLINE_BYTE) begin
			if (cfg.column_command == CMD_APPEND) begin
				m_cnt = 2'd2;
			end else begin
				m_cnt = 2'd1;
				m0    = NEWLINE_BYTE;
			end
			column_index_d = COL_W'(1);
			if (row_index_q < MAX_ROWS) row_index_d = row_index_q + ROW_W'(1);
			at_row_start_d = 1'b1;
			kept_seen_d    = 1'b0;
		end else if (is_delim) begin
			column_index_d = col_inc;
			if (cfg.column_command == CMD_DELETE) begin
				if (col_kept(cfg, col_inc)) begin
					if (kept_seen_eff) m_cnt = 2'd1;
					kept_seen_d = 1'b1;
				end
			end else begin
				m_cnt = 2'd1;
				if ((cfg.column_command == CMD_INSERT) && col_step &&
					(col_inc == cfg.first_column)) begin
					m_cnt = 2'd2;
					m1    = od;
				end
			end
		end else if (col_kept(cfg, column_index_q)) begin
			m_cnt = 2'd1;
			m0    = byte_s1;
		end

		if (pre) begin
			r0    = od;
			r1    = m0;
			n_res = (m_cnt == 2'd0) ? 2'd1 : 2'd2;
		end else begin
			r0    = m0;
			r1    = m1;
			n_res = m_cnt;
		end
		if (drop) n_res = 2'd0;

		push.cnt  = advance ? n_res : 2'd0;
		push.res0 = r0;
		push.res1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_index_q <= COL_W'(1);
			row_index_q    <= ROW_W'(1);
			at_row_start_q <= 1'b1;
			kept_seen_q    <= 1'b0;
		end else if (advance) begin
			column_index_q <= column_index_d;
			row_index_q    <= row_index_d;
			at_row_start_q <= at_row_start_d;
			kept_seen_q    <= kept_seen_d;
		end
	end

	a_row_start_col_one: assert property (@(posedge clk) disable iff (!arst_n)
		at_row_start_q |-> column_index_q == COL_W'(1))
		else $error("row start with column index not one");

	a_counters_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		column_index_q != '0 && row_index_q != '0)
		else $error("column or row counter reached zero");

	a_no_push_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> push.cnt == 2'd0 && push.cnt != 2'd3)
		else $error("results pushed without a held item");

endmodule

// File: sv/dce_result_fifo.sv
// Result buffer: takes up to two result bytes per cycle, delivers one per cycle while the consumer is ready.
// Depends on dce_pkg and dce_result_if.
module dce_result_fifo import dce_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          room,
	dce_result_if.source  result_out
);

	res_entry_t               mem [RES_DEPTH];
	logic [RES_PTR_W-1:0]     wr_q, rd_q;
	logic [RES_CNT_W-1:0]     count_q;
	logic                     pop;
	res_entry_t               e0, e1;
	res_entry_t               head;

	assign pop  = result_out.valid && result_out.ready;
	assign room = count_q <= RES_CNT_W'(RES_DEPTH - 2);

	assign e0 = '{out_byte: push.res0, last_of_run: push.cnt == 2'd1};
	assign e1 = '{out_byte: push.res1, last_of_run: 1'b1};

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem[wr_q] <= e0;
		if (push.cnt == 2'd2) mem[wr_q + RES_PTR_W'(1)] <= e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(push.cnt);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			count_q <= count_q + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
		end
	end

	assign head                   = mem[rd_q];
	assign result_out.valid       = count_q != '0;
	assign result_out.out_byte    = head.out_byte;
	assign result_out.last_of_run = head.last_of_run;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CNT_W'(RES_DEPTH))
		else $error("result buffer overfilled");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> count_q + RES_CNT_W'(push.cnt) <= RES_CNT_W'(RES_DEPTH))
		else $error("push without space");

	a_pair_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |=> count_q >= RES_CNT_W'(2))
		else $error("pair push lost an entry");

endmodule

// File: sv/delimited_column_editor_top.sv
// Delimited column editor top: configuration registers, edit stage, result buffer.
// Each accepted byte is held in the input register until the result buffer has room.
// Throughput: one byte per cycle while each byte gives at most one result and the
// result channel is ready; a byte with two results sends them one at a time on the port.
// Reset sets the column/row counters to one, empties the buffer and resets configuration.
// Depends on dce_pkg, the channel interfaces, dce_edit_core and dce_result_fifo.
module delimited_column_editor_top import dce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dce_text_if.sink     text_in,
	dce_result_if.source result_out,
	dce_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	push_t push;
	logic  room;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_set     <= DSET_W'(32);
			cfg_q.delimiter_count   <= DCNT_W'(1);
			cfg_q.column_command    <= CMD_NONE;
			cfg_q.first_column      <= COL_W'(1);
			cfg_q.last_column       <= COL_W'(1);
			cfg_q.first_dropped_row <= '0;
			cfg_q.last_dropped_row  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DELIMITER_SET:     cfg_q.delimiter_set     <= cfg.data[DSET_W-1:0];
				REG_DELIMITER_COUNT:   cfg_q.delimiter_count   <= cfg.data[DCNT_W-1:0];
				REG_COLUMN_COMMAND:    cfg_q.column_command    <= column_command_t'(cfg.data[1:0]);
				REG_FIRST_COLUMN:      cfg_q.first_column      <= cfg.data[COL_W-1:0];
				REG_LAST_COLUMN:       cfg_q.last_column       <= cfg.data[COL_W-1:0];
				REG_FIRST_DROPPED_ROW: cfg_q.first_dropped_row <= cfg.data[ROW_W-1:0];
				REG_LAST_DROPPED_ROW:  cfg_q.last_dropped_row  <= cfg.data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	dce_edit_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.cfg     (cfg_q),
		.room    (room),
		.push    (push)
	);

	dce_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.result_out (result_out)
	);

endmodule

// File: tb/dce_edit_checker.sv
// Checker for the delimited column editor: tracks the register writes, predicts the
// edited bytes of every accepted text item and compares them with the result channel.
// Depends on dce_pkg.
module dce_edit_checker import dce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	input  logic                  text_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic [BYTE_W-1:0]     out_byte,
	input  logic                  last_of_run,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t              settings;
	logic [COL_W-1:0]  column_index;
	logic [ROW_W-1:0]  row_index;
	logic              at_row_start;
	logic              kept_column_seen;
	logic [BYTE_W-1:0] edit_buf [2];
	int                edit_count;
	res_entry_t        expected_bytes [$];
	res_entry_t        head;

	function automatic logic column_kept(input logic [COL_W-1:0] c);
		return settings.column_command != CMD_DELETE ||
			!(c >= settings.first_column && c <= settings.last_column);
	endfunction

	function automatic logic is_delimiter(input logic [BYTE_W-1:0] b);
		logic [DSET_W-1:0] set_bits;
		int n;
		set_bits = settings.delimiter_set;
		n = settings.delimiter_count;
		if (n < 1) n = 1;
		if (n > MAX_DELIMS) n = MAX_DELIMS;
		for (int k = 0; k < n; k++)
			if (set_bits[k*BYTE_W +: BYTE_W] == b) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void emit(input logic [BYTE_W-1:0] b);
		if (edit_count < 2) begin
			edit_buf[edit_count] = b;
			edit_count++;
		end
	endfunction

	function automatic void edit_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] out_delim;
		logic drop;
		logic stepped;
		res_entry_t e;
		out_delim = settings.delimiter_set[BYTE_W-1:0];
		edit_count = 0;
		drop = settings.first_dropped_row != '0 &&
			row_index >= settings.first_dropped_row &&
			row_index <= settings.last_dropped_row;
		if (at_row_start) begin
			at_row_start = 1'b0;
			kept_column_seen = column_kept(COL_W'(1));
			if (settings.column_command == CMD_INSERT && settings.first_column == COL_W'(1))
				emit(out_delim);
		end
		if (b == NEWLINE_BYTE) begin
			if (settings.column_command == CMD_APPEND) emit(out_delim);
			emit(NEWLINE_BYTE);
			column_index = COL_W'(1);
			if (row_index < MAX_ROWS) row_index++;
			at_row_start = 1'b1;
			kept_column_seen = 1'b0;
		end else if (is_delimiter(b)) begin
			stepped = 1'b0;
			if (column_index < MAX_COLUMNS) begin
				column_index++;
				stepped = 1'b1;
			end
			if (settings.column_command == CMD_DELETE) begin
				if (column_kept(column_index)) begin
					if (kept_column_seen) emit(out_delim);
					kept_column_seen = 1'b1;
				end
			end else begin
				emit(out_delim);
				if (settings.column_command == CMD_INSERT && stepped &&
					column_index == settings.first_column)
					emit(out_delim);
			end
		end else if (column_kept(column_index)) begin
			emit(b);
		end
		if (!drop) begin
			for (int i = 0; i < edit_count; i++) begin
				e.out_byte = edit_buf[i];
				e.last_of_run = (i == edit_count - 1);
				expected_bytes.push_back(e);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings.delimiter_set = DSET_W'(8'h20);
			settings.delimiter_count = DCNT_W'(1);
			settings.column_command = CMD_NONE;
			settings.first_column = COL_W'(1);
			settings.last_column = COL_W'(1);
			settings.first_dropped_row = '0;
			settings.last_dropped_row = '0;
			column_index = COL_W'(1);
			row_index = ROW_W'(1);
			at_row_start = 1'b1;
			kept_column_seen = 1'b0;
			expected_bytes.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELIMITER_SET:     settings.delimiter_set = cfg_data[DSET_W-1:0];
					REG_DELIMITER_COUNT:   settings.delimiter_count = cfg_data[DCNT_W-1:0];
					REG_COLUMN_COMMAND:    settings.column_command = column_command_t'(cfg_data[1:0]);
					REG_FIRST_COLUMN:      settings.first_column = cfg_data[COL_W-1:0];
					REG_LAST_COLUMN:       settings.last_column = cfg_data[COL_W-1:0];
					REG_FIRST_DROPPED_ROW: settings.first_dropped_row = cfg_data[ROW_W-1:0];
					REG_LAST_DROPPED_ROW:  settings.last_dropped_row = cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (text_valid && text_ready) edit_byte(text_byte);
			if (result_valid && result_ready) begin
				if (expected_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual out_byte %02h last_of_run %0b",
						$time, out_byte, last_of_run);
				end else begin
					head = expected_bytes.pop_front();
					if (out_byte !== head.out_byte) begin
						mismatches++;
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, head.out_byte, out_byte);
					end
					if (last_of_run !== head.last_of_run) begin
						mismatches++;
						$display("%0t: last_of_run mismatch, expected %0b, actual %0b",
							$time, head.last_of_run, last_of_run);
					end
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// File: tb/delimited_column_editor_top_tb.sv
// Testbench top for the delimited column editor: clock, reset, register setup,
// text stimulus and result back-pressure, with dce_edit_checker scoring the output.
// Depends on dce_pkg, the channel interfaces, delimited_column_editor_top and dce_edit_checker.
module delimited_column_editor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dce_pkg::*;

	localparam int RESET_CYCLES    = 12;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int STALL_LIMIT     = 3000;
	localparam int PHASE_ITEMS     = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	int   send_idle_pct = 15;
	int   recv_idle_pct = 15;
	bit   hold_req = 1'b0;
	int   sent_items = 0;
	int   rows_seen = 0;
	int   quiet_cycles;
	cfg_t active;

	dce_text_if   text_ch ();
	dce_result_if result_ch ();
	dce_cfg_if    cfg_ch ();

	delimited_column_editor_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_ch),
		.result_out (result_ch),
		.cfg        (cfg_ch)
	);

	dce_edit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_ch.valid),
		.text_ready   (text_ch.ready),
		.text_byte    (text_ch.text_byte),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.out_byte     (result_ch.out_byte),
		.last_of_run  (result_ch.last_of_run),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_index    (cfg_ch.index),
		.cfg_data     (cfg_ch.data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_text(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_items++;
		if (b == NEWLINE_BYTE && rows_seen < MAX_ROWS) rows_seen++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_text(s[i]);
	endtask

	function automatic logic [BYTE_W-1:0] pick_delimiter();
		logic [DSET_W-1:0] set_bits;
		int n;
		int k;
		set_bits = active.delimiter_set;
		n = active.delimiter_count;
		if (n < 1) n = 1;
		if (n > MAX_DELIMS) n = MAX_DELIMS;
		k = $urandom_range(n - 1);
		return set_bits[k*BYTE_W +: BYTE_W];
	endfunction

	function automatic logic [BYTE_W-1:0] content_byte();
		if ($urandom_range(9) == 0) return BYTE_W'($urandom_range(255));
		return BYTE_W'(8'h61 + $urandom_range(25));
	endfunction

	task automatic send_row(input int cols, input int width, input bit terminated);
		int len;
		for (int c = 0; c < cols; c++) begin
			if (c > 0) send_text(pick_delimiter());
			len = $urandom_range(width);
			for (int i = 0; i < len; i++) send_text(content_byte());
		end
		if (terminated) send_text(NEWLINE_BYTE);
	endtask

	task automatic send_long_row(input int delimiters);
		for (int i = 0; i < delimiters; i++) begin
			send_text(pick_delimiter());
			if (i % 97 == 0) send_text(8'h6B);
		end
		send_text(NEWLINE_BYTE);
	endtask

	task automatic settle();
		text_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		active = s;
		put_reg(REG_DELIMITER_SET, s.delimiter_set);
		put_reg(REG_DELIMITER_COUNT, CFG_DATA_W'(s.delimiter_count));
		put_reg(REG_COLUMN_COMMAND, CFG_DATA_W'(s.column_command));
		put_reg(REG_FIRST_COLUMN, CFG_DATA_W'(s.first_column));
		put_reg(REG_LAST_COLUMN, CFG_DATA_W'(s.last_column));
		put_reg(REG_FIRST_DROPPED_ROW, CFG_DATA_W'(s.first_dropped_row));
		put_reg(REG_LAST_DROPPED_ROW, CFG_DATA_W'(s.last_dropped_row));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cfg_t make_settings(input logic [DSET_W-1:0] set_bits, input int count,
		input column_command_t cmd, input int first, input int last,
		input int first_row, input int last_row);
		cfg_t s;
		s.delimiter_set = set_bits;
		s.delimiter_count = DCNT_W'(count);
		s.column_command = cmd;
		s.first_column = COL_W'(first);
		s.last_column = COL_W'(last);
		s.first_dropped_row = ROW_W'(first_row);
		s.last_dropped_row = ROW_W'(last_row);
		return s;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t s;
		logic [BYTE_W-1:0] pool [6];
		logic [DSET_W-1:0] set_bits;
		pool = '{8'h2C, 8'h3B, 8'h20, 8'h09, 8'h7C, NEWLINE_BYTE};
		for (int k = 0; k < MAX_DELIMS; k++)
			set_bits[k*BYTE_W +: BYTE_W] = ($urandom_range(3) == 0) ?
				BYTE_W'($urandom_range(255)) : pool[$urandom_range(5)];
		s.delimiter_set = set_bits;
		s.delimiter_count = ($urandom_range(4) == 0) ? DCNT_W'($urandom_range(15)) :
			DCNT_W'($urandom_range(1, 4));
		s.column_command = column_command_t'($urandom_range(3));
		case ($urandom_range(9))
			0: s.first_column = '0;
			1: s.first_column = MAX_COLUMNS;
			2: s.first_column = COL_W'($urandom_range(1023));
			default: s.first_column = COL_W'($urandom_range(1, 4));
		endcase
		s.last_column = ($urandom_range(3) == 0) ? COL_W'($urandom_range(1023)) :
			COL_W'(s.first_column + $urandom_range(2));
		case ($urandom_range(9))
			5, 6, 7: begin
				s.first_dropped_row = ROW_W'(rows_seen + 1 + $urandom_range(15));
				s.last_dropped_row = ROW_W'(s.first_dropped_row + $urandom_range(4));
			end
			8: begin
				s.first_dropped_row = ROW_W'($urandom_range(65535));
				s.last_dropped_row = ROW_W'($urandom_range(65535));
			end
			9: begin
				s.first_dropped_row = MAX_ROWS;
				s.last_dropped_row = ROW_W'($urandom_range(65535));
			end
			default: begin
				s.first_dropped_row = '0;
				s.last_dropped_row = '0;
			end
		endcase
		return s;
	endfunction

	task automatic run_phase(input int count);
		int target;
		int r;
		target = sent_items + count;
		while (sent_items < target) begin
			r = $urandom_range(99);
			if (r < 80) send_row($urandom_range(1, 7), $urandom_range(3), 1'b1);
			else if (r < 90) send_row($urandom_range(1, 4), 3, 1'b0);
			else repeat ($urandom_range(1, 5)) send_text(BYTE_W'($urandom_range(255)));
		end
	endtask

	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (text_ch.valid && text_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DELIMITER_SET;
		cfg_ch.data = '0;
		active = make_settings(DSET_W'(8'h20), 1, CMD_NONE, 1, 1, 0, 0);
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text(8'h00);
		send_text(8'hFF);
		send_text(8'h20);
		send_text(8'h71);
		send_text(NEWLINE_BYTE);
		settle();
		apply_settings(make_settings(DSET_W'(16'h0A2C), 2, CMD_DELETE, 2, 3, 0, 0));
		send_string("a,b,c,d\n");
		settle();
		apply_settings(make_settings(DSET_W'(8'h2C), 0, CMD_INSERT, 1, 1,
			rows_seen + 2, rows_seen + 2));
		send_string("x\ny\n");
		settle();
		apply_settings(make_settings(DSET_W'(8'h2C), 1, CMD_APPEND, 0, 0, 0, 0));
		send_string("z\n");

		settle();
		apply_settings(make_settings('1, 15, CMD_DELETE, 1023, 1023, 0, 0));
		run_phase(20);
		settle();
		apply_settings(make_settings('0, 0, CMD_INSERT, 0, 0, 65535, 65535));
		run_phase(20);

		for (int p = 0; p < 8; p++) begin
			settle();
			apply_settings(random_settings());
			send_idle_pct = (p == 5) ? 0 : 15;
			recv_idle_pct = (p == 5) ? 0 : 15;
			if (p == 2) hold_req = 1'b1;
			run_phase(PHASE_ITEMS);
		end
		send_idle_pct = 15;
		recv_idle_pct = 15;

		settle();
		apply_settings(make_settings(DSET_W'(16'h3B2C), 2, CMD_INSERT, 1023, 1023, 0, 0));
		send_long_row(1024);

		settle();
		apply_settings(make_settings(DSET_W'(8'h2C), 1, CMD_NONE, 1, 1,
			rows_seen + 2, rows_seen + 3));
		repeat (4) send_row(3, 2, 1'b1);
		settle();
		apply_settings(make_settings(DSET_W'(16'h2C20), 2, CMD_APPEND, 3, 1, 0, 0));
		repeat (5) send_row($urandom_range(1, 5), 3, 1'b1);
		send_string("tail");
		settle();

		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: delimited_column_editor_top.f
sv/dce_pkg.sv
sv/dce_text_if.sv
sv/dce_result_if.sv
sv/dce_cfg_if.sv
sv/dce_edit_core.sv
sv/dce_result_fifo.sv
sv/delimited_column_editor_top.sv
tb/dce_edit_checker.sv
tb/delimited_column_editor_top_tb.sv
